[rtl/dmac_pkg.sv]
// Shared types and codes for the dual ISA DMA controller.
// Holds the request/response payload structs, the per-channel entry and the opcodes.
package dmac_pkg;

    localparam logic [3:0] OP_MODE      = 4'd0;
    localparam logic [3:0] OP_MASK      = 4'd1;
    localparam logic [3:0] OP_CLEAR     = 4'd2;
    localparam logic [3:0] OP_CLR_FF    = 4'd3;
    localparam logic [3:0] OP_STATUS    = 4'd4;
    localparam logic [3:0] OP_ADDR_WR   = 4'd5;
    localparam logic [3:0] OP_ADDR_RD   = 4'd6;
    localparam logic [3:0] OP_COUNT_WR  = 4'd7;
    localparam logic [3:0] OP_COUNT_RD  = 4'd8;
    localparam logic [3:0] OP_PAGE_WR   = 4'd9;
    localparam logic [3:0] OP_PAGE_RD   = 4'd10;
    localparam logic [3:0] OP_DREQ_ON   = 4'd11;
    localparam logic [3:0] OP_DREQ_OFF  = 4'd12;
    localparam logic [3:0] OP_TICK      = 4'd13;

    localparam logic [1:0] MODE_DEMAND  = 2'd0;
    localparam logic [1:0] MODE_SINGLE  = 2'd1;
    localparam logic [1:0] TYPE_VERIFY  = 2'd0;
    localparam logic [1:0] TYPE_WRITE   = 2'd1;
    localparam logic [1:0] TYPE_ILLEGAL = 2'd3;

    typedef struct packed {
        logic [3:0] opcode;
        logic       group;
        logic [2:0] channel;
        logic [7:0] data;
    } dmac_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        grant_valid;
        logic [2:0]  grant_channel;
        logic        xfer_valid;
        logic [2:0]  xfer_channel;
        logic [23:0] xfer_address;
        logic        xfer_to_memory;
        logic        xfer_wide;
        logic        xfer_tc;
        logic        error;
    } dmac_rsp_t;

    // mode: [5:4] mode, [3] decrement, [2] autoinit, [1:0] type
    typedef struct packed {
        logic [5:0]  mode;
        logic [15:0] cur_addr;
        logic [15:0] start_addr;
        logic [15:0] cur_count;
        logic [15:0] base_count;
        logic [7:0]  cur_page;
        logic [7:0]  base_page;
    } dmac_entry_t;

endpackage

[rtl/dmac_chan_store.sv]
// Per-channel register store: eight entries, registered read.
// Depends on dmac_pkg for the entry type; valid bits make cleared entries read as zero.
module dmac_chan_store
    import dmac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [2:0]  rd_addr,
    output dmac_entry_t rd_data,
    input  logic        wr_en,
    input  logic [2:0]  wr_addr,
    input  dmac_entry_t wr_data,
    input  logic        clr_en,
    input  logic        clr_group
);

    dmac_entry_t mem [8];
    logic [7:0]  valid_reg;
    dmac_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            // master clear drops a whole controller's four entries
            if (clr_en)
            begin
                if (clr_group)
                begin
                    valid_reg[7:4] <= 4'b0000;
                end
                else
                begin
                    valid_reg[3:0] <= 4'b0000;
                end
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/dual_isa_dma_controller_top.sv]
// Top level of the dual cascaded ISA DMA controller.
// Depends on dmac_pkg and dmac_chan_store.
//
//  channel  direction  payload     handshake
//  req      in         dmac_req_t  req_valid / req_ready
//  rsp      out        dmac_rsp_t  rsp_valid / rsp_ready
//
// Each item first reads its channel entry from the store, then updates it,
// writes it back and loads the result register.
// A new item is accepted as soon as the previous one has left the execute
// cycle, while its result may still wait in the output register.
// Reset sets the masks, clears the other flags and the store's valid bits.
// A stalled result holds the execute cycle until the output register frees.
module dual_isa_dma_controller_top
    import dmac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dmac_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output dmac_rsp_t rsp
);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t      state_reg, state_next;
    dmac_req_t   item_reg;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  request_reg, request_next;
    logic [7:0]  tc_reg, tc_next;
    logic [1:0]  ff_reg, ff_next;
    logic        busy_reg, busy_next;
    logic [2:0]  active_reg, active_next;
    logic        rsp_valid_reg;
    dmac_rsp_t   rsp_reg, rsp_next;

    logic        accept, fire;
    logic [2:0]  rd_addr;
    dmac_entry_t entry, entry_next;
    logic        wr_en, clr_en;
    logic [2:0]  wr_addr;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign fire      = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (req.opcode == OP_MODE || req.opcode == OP_MASK)
        begin
            rd_addr = {req.group, req.data[1:0]};
        end
        else if (req.opcode == OP_TICK)
        begin
            rd_addr = active_reg;
        end
        else
        begin
            rd_addr = req.channel;
        end
    end

    dmac_chan_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (rd_addr),
        .rd_data   (entry),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (entry_next),
        .clr_en    (clr_en),
        .clr_group (item_reg.group)
    );

    always_comb
    begin
        logic [2:0]  mc;
        logic [2:0]  ch;
        logic        gc;
        logic        g;
        logic [7:0]  d;
        logic [7:0]  nib;
        logic [15:0] v;
        logic [15:0] cnt;
        logic        tc;
        logic        do_arb;
        logic [7:0]  pend;
        logic        found;

        mc  = {item_reg.group, item_reg.data[1:0]};
        ch  = item_reg.channel;
        gc  = item_reg.channel[2];
        g   = item_reg.group;
        d   = item_reg.data;
        nib = g ? 8'hf0 : 8'h0f;
        v   = 16'd0;
        cnt = 16'd0;
        tc  = 1'b0;
        do_arb = 1'b0;
        pend  = 8'd0;
        found = 1'b0;

        mask_next    = mask_reg;
        request_next = request_reg;
        tc_next      = tc_reg;
        ff_next      = ff_reg;
        busy_next    = busy_reg;
        active_next  = active_reg;
        rsp_next     = '0;
        entry_next   = entry;
        wr_en        = 1'b0;
        clr_en       = 1'b0;
        wr_addr      = ch;

        case (item_reg.opcode)
            OP_MODE:
            begin
                entry_next.mode = d[7:2];
                wr_en   = 1'b1;
                wr_addr = mc;
            end
            OP_MASK:
            begin
                mask_next[mc] = d[2];
                do_arb = 1'b1;
            end
            OP_CLEAR:
            begin
                clr_en       = 1'b1;
                mask_next    = mask_reg | nib;
                request_next = request_reg & ~nib;
                tc_next      = tc_reg & ~nib;
                ff_next[g]   = 1'b0;
                if (busy_reg && active_reg[2] == g)
                begin
                    busy_next = 1'b0;
                end
            end
            OP_CLR_FF:
            begin
                ff_next[g] = 1'b0;
            end
            OP_STATUS:
            begin
                if (!g)
                begin
                    rsp_next.read_data = {request_reg[3:0], tc_reg[3:0]};
                    tc_next = tc_reg & 8'hf0;
                end
                else
                begin
                    rsp_next.read_data = {request_reg[7:4], tc_reg[7:4]};
                    tc_next = tc_reg & 8'h0f;
                end
            end
            OP_ADDR_WR, OP_COUNT_WR:
            begin
                wr_en = 1'b1;
                if (item_reg.opcode == OP_ADDR_WR)
                begin
                    if (ff_reg[gc])
                    begin
                        entry_next.cur_addr[15:8]   = d;
                        entry_next.start_addr[15:8] = d;
                    end
                    else
                    begin
                        entry_next.cur_addr[7:0]   = d;
                        entry_next.start_addr[7:0] = d;
                    end
                end
                else
                begin
                    if (ff_reg[gc])
                    begin
                        entry_next.cur_count[15:8]  = d;
                        entry_next.base_count[15:8] = d;
                    end
                    else
                    begin
                        entry_next.cur_count[7:0]  = d;
                        entry_next.base_count[7:0] = d;
                    end
                end
                ff_next[gc] = ~ff_reg[gc];
            end
            OP_ADDR_RD, OP_COUNT_RD:
            begin
                v = (item_reg.opcode == OP_ADDR_RD) ? entry.cur_addr : entry.cur_count;
                rsp_next.read_data = ff_reg[gc] ? v[15:8] : v[7:0];
                ff_next[gc] = ~ff_reg[gc];
            end
            OP_PAGE_WR:
            begin
                entry_next.cur_page  = d;
                entry_next.base_page = d;
                wr_en = 1'b1;
            end
            OP_PAGE_RD:
            begin
                rsp_next.read_data = entry.cur_page;
            end
            OP_DREQ_ON:
            begin
                request_next[ch] = 1'b1;
                do_arb = 1'b1;
            end
            OP_DREQ_OFF:
            begin
                request_next[ch] = 1'b0;
                if (busy_reg && active_reg == ch && entry.mode[5:4] == MODE_DEMAND)
                begin
                    busy_next = 1'b0;
                end
                do_arb = 1'b1;
            end
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    wr_addr = active_reg;
                    if (entry.mode[5] || entry.mode[1:0] == TYPE_VERIFY
                        || entry.mode[1:0] == TYPE_ILLEGAL)
                    begin
                        // unsupported: drop the grant, leave the channel alone
                        rsp_next.error = 1'b1;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        rsp_next.xfer_valid   = 1'b1;
                        rsp_next.xfer_channel = active_reg;
                        rsp_next.xfer_wide    = active_reg[2];
                        rsp_next.xfer_to_memory = (entry.mode[1:0] == TYPE_WRITE);
                        if (active_reg[2])
                        begin
                            rsp_next.xfer_address = {entry.cur_page[7:1], entry.cur_addr, 1'b0};
                        end
                        else
                        begin
                            rsp_next.xfer_address = {entry.cur_page, entry.cur_addr};
                        end
                        entry_next.cur_addr = entry.mode[3] ? entry.cur_addr - 16'd1
                                                            : entry.cur_addr + 16'd1;
                        cnt = entry.cur_count - 16'd1;
                        entry_next.cur_count = cnt;
                        tc = (cnt == 16'hffff);
                        if (tc)
                        begin
                            tc_next[active_reg] = 1'b1;
                            if (entry.mode[2])
                            begin
                                entry_next.cur_page  = entry.base_page;
                                entry_next.cur_addr  = entry.start_addr;
                                entry_next.cur_count = entry.base_count;
                            end
                            else
                            begin
                                mask_next[active_reg] = 1'b1;
                            end
                        end
                        rsp_next.xfer_tc = tc;
                        if (entry.mode[5:4] == MODE_SINGLE || tc)
                        begin
                            busy_next = 1'b0;
                        end
                        do_arb = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // fixed priority, lowest channel first
        if (do_arb && !busy_next)
        begin
            pend = request_next & ~mask_next;
            for (int i = 7; i >= 0; i--)
            begin
                if (pend[i])
                begin
                    found = 1'b1;
                    active_next = 3'(i);
                end
            end
            if (found)
            begin
                busy_next = 1'b1;
                rsp_next.grant_valid   = 1'b1;
                rsp_next.grant_channel = active_next;
            end
        end

        if (!fire)
        begin
            wr_en = 1'b0;
            clr_en = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mask_reg      <= 8'hff;
            request_reg   <= '0;
            tc_reg        <= '0;
            ff_reg        <= '0;
            busy_reg      <= 1'b0;
            active_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                mask_reg      <= mask_next;
                request_reg   <= request_next;
                tc_reg        <= tc_next;
                ff_reg        <= ff_next;
                busy_reg      <= busy_next;
                active_reg    <= active_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

[bench/dmac_checker.sv]
// Checker for the dual ISA DMA controller: watches both channels, predicts each
// response from its own copy of the channel state and compares it field by field.
// Depends on dmac_pkg.
module dmac_checker
    import dmac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  dmac_req_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  dmac_rsp_t rsp,
    output int        fail_count,
    output int        pending,
    output int        rsp_seen
);

    logic [5:0]  mode_r    [8];
    logic [15:0] cur_addr  [8];
    logic [15:0] start_addr[8];
    logic [15:0] cur_cnt   [8];
    logic [15:0] base_cnt  [8];
    logic [7:0]  cur_pg    [8];
    logic [7:0]  base_pg   [8];
    logic [7:0]  mask_q, dreq_q, tc_q;
    logic [1:0]  flip_q;
    logic        busy_q;
    logic [2:0]  owner_q;

    dmac_rsp_t expected_rsps[$];

    assign pending = expected_rsps.size();

    function automatic void clear_controller(input logic g);
        logic [7:0] nib;
        nib = g ? 8'hf0 : 8'h0f;
        for (int i = g * 4; i < g * 4 + 4; i++)
        begin
            mode_r[i] = '0; cur_addr[i] = '0; start_addr[i] = '0;
            cur_cnt[i] = '0; base_cnt[i] = '0; cur_pg[i] = '0; base_pg[i] = '0;
        end
        mask_q = mask_q | nib;
        dreq_q = dreq_q & ~nib;
        tc_q   = tc_q & ~nib;
        flip_q[g] = 1'b0;
        if (busy_q && owner_q[2] == g)
            busy_q = 1'b0;
    endfunction

    function automatic void grant_next(inout dmac_rsp_t r);
        logic [7:0] pend;
        if (busy_q)
            return;
        pend = dreq_q & ~mask_q;
        for (int c = 0; c < 8; c++)
        begin
            if (pend[c])
            begin
                busy_q = 1'b1;
                owner_q = c[2:0];
                r.grant_valid = 1'b1;
                r.grant_channel = c[2:0];
                return;
            end
        end
    endfunction

    function automatic void serve_tick(inout dmac_rsp_t r);
        logic [2:0] c;
        logic [1:0] md, ty;
        logic       tc;
        c = owner_q;
        md = mode_r[c][5:4];
        ty = mode_r[c][1:0];
        tc = 1'b0;
        if (md > MODE_SINGLE || ty == TYPE_VERIFY || ty == TYPE_ILLEGAL)
        begin
            r.error = 1'b1;
            busy_q = 1'b0;
            return;
        end
        r.xfer_valid = 1'b1;
        r.xfer_channel = c;
        if (c[2])
            r.xfer_address = {cur_pg[c] & 8'hfe, 16'h0} | {7'd0, cur_addr[c], 1'b0};
        else
            r.xfer_address = {cur_pg[c], cur_addr[c]};
        r.xfer_to_memory = (ty == TYPE_WRITE);
        r.xfer_wide = c[2];
        if (mode_r[c][3])
            cur_addr[c] = cur_addr[c] - 16'd1;
        else
            cur_addr[c] = cur_addr[c] + 16'd1;
        cur_cnt[c] = cur_cnt[c] - 16'd1;
        if (cur_cnt[c] == 16'hffff)
        begin
            tc = 1'b1;
            tc_q[c] = 1'b1;
            if (mode_r[c][2])
            begin
                cur_pg[c] = base_pg[c];
                cur_addr[c] = start_addr[c];
                cur_cnt[c] = base_cnt[c];
            end
            else
                mask_q[c] = 1'b1;
        end
        r.xfer_tc = tc;
        if (md == MODE_SINGLE || tc)
            busy_q = 1'b0;
        if (!busy_q)
            grant_next(r);
    endfunction

    function automatic dmac_rsp_t predict_rsp(input dmac_req_t q);
        dmac_rsp_t r;
        logic [2:0] mc, ch;
        logic       gc;
        logic [15:0] v;
        r = '0;
        ch = q.channel;
        gc = ch[2];
        mc = {q.group, q.data[1:0]};
        case (q.opcode)
            OP_MODE:
                mode_r[mc] = q.data[7:2];
            OP_MASK:
            begin
                mask_q[mc] = q.data[2];
                grant_next(r);
            end
            OP_CLEAR:
                clear_controller(q.group);
            OP_CLR_FF:
                flip_q[q.group] = 1'b0;
            OP_STATUS:
            begin
                if (!q.group)
                begin
                    r.read_data = {dreq_q[3:0], tc_q[3:0]};
                    tc_q[3:0] = '0;
                end
                else
                begin
                    r.read_data = {dreq_q[7:4], tc_q[7:4]};
                    tc_q[7:4] = '0;
                end
            end
            OP_ADDR_WR, OP_COUNT_WR:
            begin
                if (q.opcode == OP_ADDR_WR)
                begin
                    if (!flip_q[gc]) begin cur_addr[ch][7:0] = q.data; start_addr[ch][7:0] = q.data; end
                    else begin cur_addr[ch][15:8] = q.data; start_addr[ch][15:8] = q.data; end
                end
                else
                begin
                    if (!flip_q[gc]) begin cur_cnt[ch][7:0] = q.data; base_cnt[ch][7:0] = q.data; end
                    else begin cur_cnt[ch][15:8] = q.data; base_cnt[ch][15:8] = q.data; end
                end
                flip_q[gc] = ~flip_q[gc];
            end
            OP_ADDR_RD, OP_COUNT_RD:
            begin
                v = (q.opcode == OP_ADDR_RD) ? cur_addr[ch] : cur_cnt[ch];
                r.read_data = flip_q[gc] ? v[15:8] : v[7:0];
                flip_q[gc] = ~flip_q[gc];
            end
            OP_PAGE_WR:
            begin
                cur_pg[ch] = q.data;
                base_pg[ch] = q.data;
            end
            OP_PAGE_RD:
                r.read_data = cur_pg[ch];
            OP_DREQ_ON:
            begin
                dreq_q[ch] = 1'b1;
                grant_next(r);
            end
            OP_DREQ_OFF:
            begin
                dreq_q[ch] = 1'b0;
                if (busy_q && owner_q == ch && mode_r[ch][5:4] == MODE_DEMAND)
                    busy_q = 1'b0;
                grant_next(r);
            end
            OP_TICK:
                if (busy_q)
                    serve_tick(r);
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch on response %0d: %s got %0h expected %0h", rsp_seen, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        rsp_seen = 0;
        busy_q = 1'b0; owner_q = '0; mask_q = 8'hff; dreq_q = '0; tc_q = '0; flip_q = '0;
        clear_controller(1'b0);
        clear_controller(1'b1);
    end

    always @(posedge clk)
    begin
        dmac_rsp_t e;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("response %0d arrived with nothing expected", rsp_seen);
                    fail_count++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp.read_data != e.read_data)
                        report_mismatch("read_data", 24'(rsp.read_data), 24'(e.read_data));
                    if (rsp.grant_valid != e.grant_valid)
                        report_mismatch("grant_valid", 24'(rsp.grant_valid),
                                        24'(e.grant_valid));
                    if (rsp.grant_channel != e.grant_channel)
                        report_mismatch("grant_channel", 24'(rsp.grant_channel),
                                        24'(e.grant_channel));
                    if (rsp.xfer_valid != e.xfer_valid)
                        report_mismatch("xfer_valid", 24'(rsp.xfer_valid), 24'(e.xfer_valid));
                    if (rsp.xfer_channel != e.xfer_channel)
                        report_mismatch("xfer_channel", 24'(rsp.xfer_channel),
                                        24'(e.xfer_channel));
                    if (rsp.xfer_address != e.xfer_address)
                        report_mismatch("xfer_address", rsp.xfer_address, e.xfer_address);
                    if (rsp.xfer_to_memory != e.xfer_to_memory)
                        report_mismatch("xfer_to_memory", 24'(rsp.xfer_to_memory),
                                        24'(e.xfer_to_memory));
                    if (rsp.xfer_wide != e.xfer_wide)
                        report_mismatch("xfer_wide", 24'(rsp.xfer_wide), 24'(e.xfer_wide));
                    if (rsp.xfer_tc != e.xfer_tc)
                        report_mismatch("xfer_tc", 24'(rsp.xfer_tc), 24'(e.xfer_tc));
                    if (rsp.error != e.error)
                        report_mismatch("error", 24'(rsp.error), 24'(e.error));
                end
                rsp_seen++;
            end
            if (req_valid && req_ready)
                expected_rsps.push_back(predict_rsp(req));
        end
    end

endmodule

[bench/dual_isa_dma_controller_top_test.sv]
// Stimulus and verdict for the dual ISA DMA controller: directed and random
// register, DREQ and tick sequences. Depends on dmac_pkg and dmac_checker.
module dual_isa_dma_controller_top_test;
    import dmac_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    dmac_req_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    dmac_rsp_t rsp;
    int        fail_count, pending, rsp_seen;
    int        idle_cycles;
    int        sent;
    int        stall_mode;

    dual_isa_dma_controller_top dut (.*);

    dmac_checker checker_i (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver stalls in phases: none, light, heavy.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b1;
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("** dual_isa_dma_controller_top: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input logic [3:0] op, input logic g, input logic [2:0] ch,
                             input logic [7:0] d);
        req_valid <= 1'b1;
        req <= '{opcode: op, group: g, channel: ch, data: d};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent++;
        // Random gap between bursts.
        if ($urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Program one channel for a short transfer with random settings.
    task automatic setup_channel(input logic [2:0] ch, input logic [1:0] md,
                                 input logic [1:0] ty);
        logic [7:0] mb;
        mb = {md, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, ty, ch[1:0]};
        send_item(OP_MODE, ch[2], ch, mb);
        send_item(OP_CLR_FF, ch[2], ch, 8'($urandom));
        send_item(OP_ADDR_WR, ch[2], ch, 8'($urandom));
        send_item(OP_ADDR_WR, ch[2], ch, 8'($urandom));
        send_item(OP_COUNT_WR, ch[2], ch, 8'($urandom_range(0, 4)));
        send_item(OP_COUNT_WR, ch[2], ch, ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00);
        send_item(OP_PAGE_WR, ch[2], ch, 8'($urandom));
        send_item(OP_MASK, ch[2], ch, {5'($urandom), 1'b0, ch[1:0]});
    endtask

    initial
    begin
        logic [2:0] ch;
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b1;
        stall_mode = 0;
        sent = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every opcode, priority and terminal count.
        send_item(OP_STATUS, 1'b0, 3'd0, 8'h00);
        send_item(OP_ADDR_RD, 1'b0, 3'd7, 8'hff);
        setup_channel(3'd7, MODE_SINGLE, TYPE_WRITE);
        setup_channel(3'd0, MODE_DEMAND, 2'd2);
        send_item(OP_DREQ_ON, 1'b0, 3'd7, 8'h00);
        send_item(OP_DREQ_ON, 1'b0, 3'd0, 8'h00);
        send_item(OP_TICK, 1'b0, 3'd0, 8'h00);
        send_item(OP_DREQ_OFF, 1'b0, 3'd0, 8'h00);
        send_item(OP_TICK, 1'b1, 3'd7, 8'hff);
        send_item(OP_STATUS, 1'b1, 3'd0, 8'h00);
        send_item(OP_COUNT_RD, 1'b1, 3'd7, 8'h00);
        send_item(OP_PAGE_RD, 1'b1, 3'd7, 8'h00);
        send_item(OP_MODE, 1'b1, 3'd0, 8'b1000_0001);
        send_item(OP_MASK, 1'b1, 3'd0, 8'h01);
        send_item(OP_DREQ_ON, 1'b1, 3'd5, 8'h00);
        send_item(OP_TICK, 1'b0, 3'd0, 8'h00);
        send_item(OP_CLEAR, 1'b1, 3'd0, 8'h00);
        send_item(4'd14, 1'b0, 3'd0, 8'h00);
        send_item(4'd15, 1'b1, 3'd7, 8'hff);

        // Random: mostly programmed channels with DREQ and tick runs, some noise.
        while (sent < 440)
        begin
            ch = 3'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    setup_channel(ch, ($urandom_range(0, 7) == 0) ? 2'($urandom) :
                                  2'($urandom_range(0, 1)),
                                  ($urandom_range(0, 7) == 0) ? 2'($urandom) :
                                  2'($urandom_range(1, 2)));
                    send_item(OP_DREQ_ON, 1'($urandom), ch, 8'($urandom));
                    repeat ($urandom_range(1, 8))
                        send_item(OP_TICK, 1'($urandom), 3'($urandom), 8'($urandom));
                end
                4, 5:
                    send_item(OP_TICK, 1'($urandom), ch, 8'($urandom));
                6:
                    send_item(OP_DREQ_OFF, 1'($urandom), ch, 8'($urandom));
                7:
                    send_item(4'($urandom_range(OP_STATUS, OP_PAGE_RD)), 1'($urandom), ch,
                              8'($urandom));
                8:
                    send_item(4'($urandom), 1'($urandom), ch, 8'($urandom));
                default:
                    send_item(($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_CLR_FF,
                              1'($urandom), ch, 8'($urandom));
            endcase
        end
        req_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        $display("sent %0d items, checked %0d responses across all opcodes and channels",
                 sent, rsp_seen);
        if (fail_count == 0)
            $display("** dual_isa_dma_controller_top: PASSED **");
        else
            $display("** dual_isa_dma_controller_top: FAILED **");
        $finish;
    end

endmodule
